// ===== rtl/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// rts_pkg: shared types and constants for the repeating timer scheduler
// Holds the timer count, operation codes and the entry record type.
// ----------------------------------------------------------------------------
`default_nettype none
package rts_pkg;
	localparam int TimerCount = 16;
	localparam int IdW = (TimerCount > 1) ? $clog2(TimerCount) : 1;
	localparam int CntW = $clog2(TimerCount + 1);
	localparam int FireLimit = 16;

	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_STOP   = 3'd1;
	localparam logic [2:0] OP_AGAIN  = 3'd2;
	localparam logic [2:0] OP_REPEAT = 3'd3;
	localparam logic [2:0] OP_RUN    = 3'd4;
	localparam logic [2:0] OP_QUERY  = 3'd5;

	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] WAIT_NONE = 32'hffff_ffff;

	typedef struct packed {
		logic [63:0] deadline;
		logic [63:0] order;
	} key_t;

	// strict ordering of (deadline, arming sequence)
	function automatic logic earlier(key_t a, key_t b);
		if (a.deadline != b.deadline) return a.deadline < b.deadline;
		return a.order < b.order;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/rts_scan.sv =====
// ----------------------------------------------------------------------------
// rts_scan: sequential minimum search over the timer table
// Visits one entry per cycle and keeps the earliest eligible one.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_scan (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 elig,
	input  wire rts_pkg::key_t        key,
	output logic [rts_pkg::IdW-1:0]   idx,
	output logic                      done,
	output logic                      found,
	output logic [rts_pkg::IdW-1:0]   best_id,
	output logic [63:0]               best_deadline
);
	import rts_pkg::*;

	logic          busy_q;
	logic [IdW-1:0] idx_q;
	logic          found_q;
	logic [IdW-1:0] best_q;
	key_t          bkey_q;
	logic          take;

	assign idx = idx_q;
	assign take = busy_q && elig && (!found_q || earlier(key, bkey_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				found_q <= 1'b0;
			end else if (busy_q) begin
				if (take) found_q <= 1'b1;
				if (idx_q == IdW'(TimerCount - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= idx_q;
			bkey_q <= key;
		end
	end

	assign found = found_q;
	assign best_id = best_q;
	assign best_deadline = bkey_q.deadline;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> !done)
		else $error("scan done right after start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("scan still busy when done");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && idx_q != IdW'(TimerCount - 1)) |=> busy_q)
		else $error("scan stopped early");
endmodule
`default_nettype wire

// ===== rtl/repeating_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// repeating_timer_scheduler: table of repeating timers with ordered firing
// Start, stop, again, set repeat, run and query over a small timer table.
// ----------------------------------------------------------------------------
// channel  direction  handshake          fields
// in       input      in_valid/in_stall  op timer_id delay repeat_interval now
// out      output     out_valid/out_stall status fired fired_id next_wait last
//
// table ops go through the exec and output states; query scans the table once
// run scans the table once per fired timer plus a closing scan, and passes
// through the output state only when nothing fires
// reset clears all timers, the sequence counter and the current time
// out_stall holds the result register and the sequencer, and stalls the input
// while a result waits
`default_nettype none
module repeating_timer_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [3:0]  timer_id,
	input  wire logic [63:0] delay,
	input  wire logic [63:0] repeat_interval,
	input  wire logic [63:0] now,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic             fired,
	output logic [3:0]       fired_id,
	output logic signed [31:0] next_wait,
	output logic             last
);
	import rts_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_FIRE = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [2:0]  op_q;
	logic [3:0]  id_q;
	logic [63:0] delay_q, ivl_q, now_q;
	logic [TimerCount-1:0] armed_q, ever_q, done_q;
	logic [63:0] deadline_q [TimerCount];
	logic [63:0] reload_q [TimerCount];
	logic [63:0] order_q [TimerCount];
	logic [63:0] ocnt_q, time_q;
	logic [CntW-1:0] cnt_q;

	logic        scan_start;
	logic [IdW-1:0] sidx, sbest;
	logic        sdone, sfound;
	logic [63:0] sdl;
	logic        elig;
	key_t        skey;
	logic        fire_go;
	logic        due_next;
	logic        emit;

	// single arming path shared by start, again and firing
	logic        arm_en;
	logic [IdW-1:0] arm_t;
	logic [63:0] arm_dly, arm_ivl, arm_sum;
	logic [64:0] arm_raw;

	logic id_ok;
	logic [IdW-1:0] tid;

	assign id_ok = {28'd0, id_q} < 32'(TimerCount);
	assign tid = IdW'(id_q);

	assign elig = armed_q[sidx] && (state_q != S_SCAN || op_q != OP_RUN || !done_q[sidx]);
	assign skey = '{deadline: deadline_q[sidx], order: order_q[sidx]};

	rts_scan u_scan (
		.clk, .arst_n, .start(scan_start), .elig, .key(skey), .idx(sidx),
		.done(sdone), .found(sfound), .best_id(sbest), .best_deadline(sdl)
	);

	assign fire_go = !out_valid || !out_stall;
	assign due_next = sfound && (sdl <= time_q) && (32'(cnt_q) < 32'(FireLimit));
	assign emit = (state_q == S_OUT && fire_go)
		|| (state_q == S_WAIT && op_q == OP_RUN && cnt_q != '0);

	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign scan_start = (state_q == S_EXEC && (op_q == OP_RUN || op_q == OP_QUERY))
		|| (state_q == S_FIRE && fire_go);
	assign arm_raw = {1'b0, time_q} + {1'b0, arm_dly};
	assign arm_sum = arm_raw[64] ? '1 : arm_raw[63:0];

	always_comb begin
		arm_en = 1'b0;
		arm_t = tid;
		arm_dly = delay_q;
		arm_ivl = ivl_q;
		if (state_q == S_EXEC && id_ok) begin
			if (op_q == OP_START) arm_en = 1'b1;
			else if (op_q == OP_AGAIN && ever_q[tid] && reload_q[tid] != 64'd0) begin
				arm_en = 1'b1;
				arm_dly = reload_q[tid];
				arm_ivl = reload_q[tid];
			end
		end else if (state_q == S_FIRE && fire_go && reload_q[sbest] != 64'd0) begin
			arm_en = 1'b1;
			arm_t = sbest;
			arm_dly = reload_q[sbest];
			arm_ivl = reload_q[sbest];
		end
	end

	always_ff @(posedge clk) begin
		if (arm_en) begin
			deadline_q[arm_t] <= arm_sum;
			reload_q[arm_t] <= arm_ivl;
			order_q[arm_t] <= ocnt_q;
		end else if (state_q == S_EXEC && id_ok && op_q == OP_REPEAT) begin
			reload_q[tid] <= ivl_q;
		end
		if (state_q == S_IDLE && in_valid) begin
			op_q <= op;
			id_q <= timer_id;
			delay_q <= delay;
			ivl_q <= repeat_interval;
			now_q <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			armed_q <= '0;
			ever_q <= '0;
			done_q <= '0;
			ocnt_q <= '0;
			time_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
			status <= 1'b0;
			fired <= 1'b0;
			fired_id <= '0;
			next_wait <= '0;
			last <= 1'b0;
		end else begin
			out_valid <= emit || (out_valid && out_stall);
			if (arm_en) begin
				armed_q[arm_t] <= 1'b1;
				ever_q[arm_t] <= 1'b1;
				ocnt_q <= ocnt_q + 64'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) state_q <= S_EXEC;
				end
				S_EXEC: begin
					status <= 1'b0;
					fired <= 1'b0;
					fired_id <= '0;
					next_wait <= '0;
					last <= 1'b1;
					if (op_q == OP_RUN) begin
						time_q <= now_q;
						done_q <= '0;
						cnt_q <= '0;
						state_q <= S_SCAN;
					end else if (op_q == OP_QUERY) begin
						state_q <= S_SCAN;
					end else begin
						if (id_ok && op_q == OP_STOP) armed_q[tid] <= 1'b0;
						if (id_ok && op_q == OP_AGAIN && !ever_q[tid]) status <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_SCAN: begin
					if (sdone) state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (op_q == OP_QUERY) begin
						if (!sfound) next_wait <= WAIT_NONE;
						else if (sdl <= time_q) next_wait <= '0;
						else if (sdl - time_q > {32'd0, INT_MAX}) next_wait <= INT_MAX;
						else next_wait <= 32'(sdl - time_q);
						state_q <= S_OUT;
					end else if (due_next) begin
						state_q <= S_FIRE;
					end else if (cnt_q == '0) begin
						state_q <= S_OUT;
					end else begin
						// nothing more due or fire limit reached: the held expiry closes the run
						last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FIRE: begin
					if (fire_go) begin
						if (reload_q[sbest] == 64'd0) armed_q[sbest] <= 1'b0;
						done_q[sbest] <= 1'b1;
						status <= 1'b0;
						fired <= 1'b1;
						fired_id <= 4'(sbest);
						next_wait <= '0;
						last <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (fire_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIRE) |-> (sfound && sdl <= time_q))
		else $error("firing a timer that is not due");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");
endmodule
`default_nettype wire

// ===== bench/repeating_timer_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// repeating_timer_scheduler_tb: self-checking bench for the timer scheduler
// Drives a table of directed operations and then random traffic (start/stop/
// again/repeat/run/query and undefined op codes, time mostly rising) under
// several idling and stalling phases, predicting each result from its own timer
// table and comparing every output item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module repeating_timer_scheduler_tb;
	import rts_pkg::*;

	typedef struct packed {
		logic        status;
		logic        fired;
		logic [3:0]  fired_id;
		logic [31:0] next_wait;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  id;
		logic [63:0] dly;
		logic [63:0] rep;
		logic [63:0] tnow;
		logic        chk;
		logic [31:0] want_wait;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] op = '0;
	logic [3:0] timer_id = '0;
	logic [63:0] delay = '0;
	logic [63:0] repeat_interval = '0;
	logic [63:0] now = '0;
	logic out_valid;
	logic out_stall = 0;
	logic status, fired, last;
	logic [3:0] fired_id;
	logic signed [31:0] next_wait;

	repeating_timer_scheduler dut (.*);

	always #4 clk = ~clk;

	// timer table mirror
	logic        t_armed [TimerCount];
	logic        t_seen [TimerCount];
	logic [63:0] t_due [TimerCount];
	logic [63:0] t_rel [TimerCount];
	logic [63:0] t_seq [TimerCount];
	logic [63:0] seq_count = 0;
	logic [63:0] cur_time = 0;
	logic [63:0] time_base = 0;

	res_t pending_results[$];
	int errors = 0, items_sent = 0, results_seen = 0, fires_seen = 0;
	int send_idle = 0, recv_stall = 0;

	initial for (int i = 0; i < TimerCount; i++) begin
		t_armed[i] = 0; t_seen[i] = 0; t_due[i] = 0; t_rel[i] = 0; t_seq[i] = 0;
	end

	function automatic void arm(int t, logic [63:0] d, logic [63:0] r);
		logic [64:0] sum;
		sum = {1'b0, cur_time} + {1'b0, d};
		t_due[t] = sum[64] ? '1 : sum[63:0];
		t_rel[t] = r;
		t_seq[t] = seq_count;
		seq_count = seq_count + 1;
		t_armed[t] = 1;
		t_seen[t] = 1;
	endfunction

	function automatic logic before_t(int a, int b);
		if (t_due[a] != t_due[b]) return t_due[a] < t_due[b];
		return t_seq[a] < t_seq[b];
	endfunction

	function automatic void predict_timers(row_t r);
		res_t x;
		logic done [TimerCount];
		int cnt, m;
		logic [63:0] w;
		x = '0;
		x.last = 1;
		if (r.op == OP_RUN) begin
			cur_time = r.tnow;
			cnt = 0;
			for (int i = 0; i < TimerCount; i++) done[i] = 0;
			while (cnt < FireLimit) begin
				m = -1;
				for (int i = 0; i < TimerCount; i++)
					if (t_armed[i] && !done[i] && (m < 0 || before_t(i, m))) m = i;
				if (m < 0 || t_due[m] > cur_time) break;
				done[m] = 1;
				t_armed[m] = 0;
				if (t_rel[m] != 0) arm(m, t_rel[m], t_rel[m]);
				x = '0;
				x.fired = 1;
				x.fired_id = m[3:0];
				pending_results.push_back(x);
				cnt++;
			end
			if (cnt == 0) begin
				x = '0;
				x.last = 1;
				pending_results.push_back(x);
			end else begin
				x = pending_results.pop_back();
				x.last = 1;
				pending_results.push_back(x);
			end
			return;
		end
		if (r.op == OP_QUERY) begin
			m = -1;
			for (int i = 0; i < TimerCount; i++)
				if (t_armed[i] && (m < 0 || before_t(i, m))) m = i;
			if (m < 0) w = {32'd0, WAIT_NONE};
			else if (t_due[m] <= cur_time) w = 0;
			else begin
				w = t_due[m] - cur_time;
				if (w > {32'd0, INT_MAX}) w = {32'd0, INT_MAX};
			end
			x.next_wait = w[31:0];
		end else if (r.id < TimerCount) begin
			case (r.op)
				OP_START: begin
					t_armed[r.id] = 0;
					arm(r.id, r.dly, r.rep);
				end
				OP_STOP: t_armed[r.id] = 0;
				OP_AGAIN: begin
					if (!t_seen[r.id]) x.status = 1;
					else if (t_rel[r.id] != 0) arm(r.id, t_rel[r.id], t_rel[r.id]);
				end
				OP_REPEAT: t_rel[r.id] = r.rep;
				default: ;
			endcase
		end
		pending_results.push_back(x);
	endfunction

	// output checking
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n) out_stall <= ($urandom_range(99) < recv_stall);
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, fired, fired_id, next_wait, last};
			results_seen++;
			if (fired) fires_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected st=%b f=%b id=%0d w=%0d l=%b, got st=%b f=%b id=%0d w=%0d l=%b",
							results_seen, want.status, want.fired, want.fired_id,
							$signed(want.next_wait), want.last, got.status, got.fired,
							got.fired_id, $signed(got.next_wait), got.last);
				end
			end
		end
	end

	task automatic send(row_t r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		op <= r.op;
		timer_id <= r.id;
		delay <= r.dly;
		repeat_interval <= r.rep;
		now <= r.tnow;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_timers(r);
		if (r.chk && pending_results[$].next_wait !== r.want_wait) begin
			errors++;
			if (errors <= 10) $display("directed row %0d: predictor disagrees", items_sent);
		end
		items_sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic row_t mk(logic [2:0] o, logic [3:0] i, logic [63:0] d,
		logic [63:0] r, logic [63:0] n, logic c, logic [31:0] w);
		row_t x;
		x = '{o, i, d, r, n, c, w};
		return x;
	endfunction

	function automatic row_t rand_row();
		row_t r;
		int k;
		k = $urandom_range(99);
		r = mk(OP_QUERY, 4'($urandom), 0, 0, 0, 0, 0);
		if (k < 25) begin
			r.op = OP_START;
			case ($urandom_range(3))
				0: r.dly = 64'($urandom_range(40));
				1: r.dly = 64'($urandom);
				2: r.dly = rand64();
				3: r.dly = '1;
			endcase
			r.rep = ($urandom_range(2) == 0) ? 64'd0 :
				($urandom_range(5) == 0) ? rand64() : 64'($urandom_range(1, 60));
		end else if (k < 32) r.op = OP_STOP;
		else if (k < 40) r.op = OP_AGAIN;
		else if (k < 46) begin
			r.op = OP_REPEAT;
			r.rep = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(60));
		end else if (k < 78) begin
			r.op = OP_RUN;
			if ($urandom_range(30) == 0) time_base = rand64();
			else time_base = time_base + 64'($urandom_range(50));
			r.tnow = time_base;
		end else if (k < 95) r.op = OP_QUERY;
		else r.op = 3'($urandom_range(6, 7));
		if ($urandom_range(9) == 0) begin
			r.dly = rand64(); r.rep = rand64(); r.tnow = rand64();
		end else if (r.op != OP_RUN) r.tnow = rand64();
		return r;
	endfunction

	row_t directed [] = '{
		mk(OP_QUERY, 0, 0, 0, 0, 1, WAIT_NONE),
		mk(OP_AGAIN, 3, 0, 0, 0, 0, 0),
		mk(OP_START, 0, 10, 0, 0, 0, 0),
		mk(OP_START, 15, 10, 5, 0, 0, 0),
		mk(OP_START, 7, '1, '1, 0, 0, 0),
		mk(OP_QUERY, 0, 0, 0, 0, 1, 32'd10),
		mk(OP_RUN, 0, 0, 0, 64'd9, 0, 0),
		mk(OP_RUN, 0, 0, 0, 64'd10, 0, 0),
		mk(OP_QUERY, 0, 0, 0, 0, 1, 32'd5),
		mk(OP_REPEAT, 15, 0, 0, 0, 0, 0),
		mk(OP_AGAIN, 15, 0, 0, 0, 0, 0),
		mk(OP_AGAIN, 0, 0, 0, 0, 0, 0),
		mk(OP_STOP, 15, 0, 0, 0, 0, 0),
		mk(OP_START, 2, 64'h1_0000_0000, 0, 0, 0, 0),
		mk(OP_QUERY, 0, 0, 0, 0, 1, INT_MAX),
		mk(3'd6, 1, '1, '1, '1, 0, 0),
		mk(3'd7, 1, 0, 0, 0, 0, 0),
		mk(OP_START, 3, 0, 1, 0, 0, 0),
		mk(OP_START, 4, 0, 1, 0, 0, 0),
		mk(OP_RUN, 0, 0, 0, '1, 0, 0),
		mk(OP_RUN, 0, 0, 0, '1, 0, 0),
		mk(OP_QUERY, 0, 0, 0, 0, 1, 32'd0),
		mk(OP_RUN, 0, 0, 0, 64'd5, 0, 0),
		mk(OP_QUERY, 0, 0, 0, 0, 0, 0)
	};

	initial begin
		#50_000_000;
		$display("repeating_timer_scheduler: mismatch");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send(directed[i]);
		time_base = cur_time;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 66) : 0;
			recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 38 : 66) : 0;
			for (int n = 0; n < 115; n++) begin
				if (n == 60) begin
					in_valid <= 0;
					@(posedge clk);
					while (pending_results.size() != 0) @(posedge clk);
				end
				send(rand_row());
			end
		end
		in_valid <= 0;
		recv_stall = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("ran %0d items, checked %0d results of which %0d were timer expiries",
			items_sent, results_seen, fires_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("repeating_timer_scheduler: match");
		else
			$display("repeating_timer_scheduler: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
